>>> sv/delta_yuv_to_rgb_decoder_top_assert.svh
// assertion macros for the delta yuv decoder
// expects clk and rst_n in the scope of the module that uses them
`ifndef DELTA_YUV_TO_RGB_DECODER_TOP_ASSERT_SVH
`define DELTA_YUV_TO_RGB_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DYUV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dyuv same-cycle check failed");

// next-cycle implication, checked out of reset
`define DYUV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dyuv next-cycle check failed");

`endif

>>> sv/dyuv_pkg.sv
// types, constants and pixel maths for the delta yuv decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dyuv_pkg;

  // register indexes (address bit 2 of the config port)
  localparam logic REG_INITIAL_YUV = 1'b0;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned YUV_W      = 24;

  // matrix coefficients, all scaled by 256
  localparam logic [9:0] K_RV = 10'd351;
  localparam logic [9:0] K_GV = 10'd179;
  localparam logic [9:0] K_GU = 10'd86;
  localparam logic [9:0] K_BU = 10'd444;
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  // bias that turns the floor shift by 256 into truncation toward zero
  localparam logic signed [19:0] TRUNC_BIAS = 20'sd255;

  localparam logic [7:0] DEQUANT [16] = '{
    8'd0,   8'd1,   8'd4,   8'd9,   8'd16,  8'd27,  8'd44,  8'd79,
    8'd128, 8'd177, 8'd212, 8'd229, 8'd240, 8'd247, 8'd252, 8'd255
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] dequant(input logic [3:0] code);
    return DEQUANT[code];
  endfunction

  // k*(c-128)/256, truncated toward zero
  function automatic logic signed [9:0] chroma_term(input logic [9:0] k,
                                                    input logic [7:0] c);
    logic signed [10:0] ks;
    logic signed [8:0]  d;
    logic signed [19:0] p;
    logic signed [19:0] adj;
    ks  = $signed({1'b0, k});
    d   = $signed({1'b0, c}) - CHROMA_OFFSET;
    p   = ks * d;
    adj = p[19] ? (p + TRUNC_BIAS) : p;
    return adj[17:8];
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x[10]) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic rgb_t yuv_to_rgb(input logic [7:0] y,
                                      input logic [7:0] u,
                                      input logic [7:0] v);
    logic signed [9:0]  t_rv;
    logic signed [9:0]  t_gu;
    logic signed [9:0]  t_gv;
    logic signed [9:0]  t_bu;
    logic signed [10:0] yy;
    rgb_t               px;
    t_rv = chroma_term(K_RV, v);
    t_gu = chroma_term(K_GU, u);
    t_gv = chroma_term(K_GV, v);
    t_bu = chroma_term(K_BU, u);
    yy   = $signed({3'b000, y});
    px.red   = clamp_u8(yy + $signed({t_rv[9], t_rv}));
    px.green = clamp_u8(yy - ($signed({t_gu[9], t_gu}) + $signed({t_gv[9], t_gv})));
    px.blue  = clamp_u8(yy + $signed({t_bu[9], t_bu}));
    return px;
  endfunction

endpackage

`default_nettype wire

>>> sv/delta_yuv_to_rgb_decoder_top.sv
// delta yuv pixel-pair decoder: top level with config port, state and pipeline
// depends on dyuv_pkg and delta_yuv_to_rgb_decoder_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "delta_yuv_to_rgb_decoder_top_assert.svh"

//  channel | direction | handshake         | beat carries
//  --------+-----------+-------------------+-----------------------------------------
//  in_     | sink      | in_valid/in_ready | delta word (4 codes) and line start flag
//  out_    | source    | out_valid/ready   | two rgb pixels, 8 bits a channel
//  cfg_    | apb slave | psel/penable      | initial_yuv at byte address 0
//
//  one beat a cycle sustained while out_ready holds high; a beat passes the input register, then the result register
//  an input register and a result register part the channels, so a new beat
//  is taken while a finished result waits on out_ready
//  decode, state update and the yuv to rgb matrix sit between the two registers
//  rst_n is synchronous: both stages empty, previous and initial yuv cleared
//  stalls on out_ready back up through the input register to in_ready

module delta_yuv_to_rgb_decoder_top (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [15:0]                      in_delta_word,
  input  wire                              in_line_start,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [7:0]                       out_first_red,
  output logic [7:0]                       out_first_green,
  output logic [7:0]                       out_first_blue,
  output logic [7:0]                       out_second_red,
  output logic [7:0]                       out_second_green,
  output logic [7:0]                       out_second_blue,
  // configuration port
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [dyuv_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [dyuv_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dyuv_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import dyuv_pkg::*;

  // config register
  logic [YUV_W-1:0] initial_yuv_r;
  logic             cfg_wr;

  // input stage
  logic             in_valid_r;
  logic [15:0]      delta_r;
  logic             line_start_r;

  // running yuv, updated as a beat moves into the result register
  logic [YUV_W-1:0] prev_yuv_r;
  logic [YUV_W-1:0] prev_yuv_nxt;

  // result stage
  logic             out_valid_r;
  rgb_t             first_px_r;
  rgb_t             second_px_r;
  rgb_t             first_px_nxt;
  rgb_t             second_px_nxt;

  logic             advance;

  // decode datapath
  logic [YUV_W-1:0] base_yuv;
  logic [7:0]       py, pu, pv;
  logic [7:0]       y1, y2, u2, v2;
  logic [8:0]       u_sum, v_sum;
  logic [7:0]       u1, v1;

  // apb: always ready, one register decoded on the word address bit
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_INITIAL_YUV);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_INITIAL_YUV) begin
      cfg_prdata = {{(CFG_DATA_W-YUV_W){1'b0}}, initial_yuv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_yuv_r <= '0;
    end else if (cfg_wr) begin
      initial_yuv_r <= cfg_pwdata[YUV_W-1:0];
    end
  end

  // pipeline control: the held beat moves on when the result slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      delta_r      <= in_delta_word;
      line_start_r <= in_line_start;
    end
  end

  // delta decode: line start reloads from the initial value first
  always_comb begin
    base_yuv = line_start_r ? initial_yuv_r : prev_yuv_r;
    py = base_yuv[23:16];
    pu = base_yuv[15:8];
    pv = base_yuv[7:0];

    // component adds wrap modulo 256
    u2 = pu + dequant(delta_r[15:12]);
    y1 = py + dequant(delta_r[11:8]);
    v2 = pv + dequant(delta_r[7:4]);
    y2 = y1 + dequant(delta_r[3:0]);

    // first pixel chroma is the mean of old and new
    u_sum = {1'b0, pu} + {1'b0, u2};
    v_sum = {1'b0, pv} + {1'b0, v2};
    u1    = u_sum[8:1];
    v1    = v_sum[8:1];

    prev_yuv_nxt  = {y2, u2, v2};
    first_px_nxt  = yuv_to_rgb(y1, u1, v1);
    second_px_nxt = yuv_to_rgb(y2, u2, v2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_yuv_r <= '0;
    end else if (advance) begin
      prev_yuv_r <= prev_yuv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      first_px_r  <= first_px_nxt;
      second_px_r <= second_px_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_red    = first_px_r.red;
  assign out_first_green  = first_px_r.green;
  assign out_first_blue   = first_px_r.blue;
  assign out_second_red   = second_px_r.red;
  assign out_second_green = second_px_r.green;
  assign out_second_blue  = second_px_r.blue;

  // a beat that moves on always lands in the result register
  `DYUV_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  // a held beat is not dropped while the result side stalls
  `DYUV_ASSERT_NEXT(a_hold_in_stage, in_valid_r && !advance, in_valid_r)
  // in_ready only drops with both stages full and the output stalled
  `DYUV_ASSERT_NOW(a_ready_low_full, !in_ready, in_valid_r && out_valid_r && !out_ready)
  // running yuv changes only when a beat is decoded
  `DYUV_ASSERT_NEXT(a_state_stable, !advance, $stable(prev_yuv_r))
  // a config write lands in the register
  `DYUV_ASSERT_NEXT(a_cfg_write, cfg_wr, initial_yuv_r == $past(cfg_pwdata[YUV_W-1:0]))

endmodule

`default_nettype wire
